### hw/rtl/ssp_pkg.sv
package ssp_pkg;

	localparam int unsigned FieldW = 16;

	localparam logic [15:0] MIN_STEP_US = 16'd1000;
	localparam logic [19:0] US_PER_S    = 20'd1000000;
	localparam logic [15:0] Q15_ONE     = 16'h8000;

	localparam logic [7:0] REG_PROP_GAIN   = 8'd0;
	localparam logic [7:0] REG_DERIV_GAIN  = 8'd1;
	localparam logic [7:0] REG_FORCE_LIMIT = 8'd2;
	localparam logic [7:0] REG_STOP_ZONE   = 8'd3;

	localparam logic [15:0] PROP_GAIN_RST   = 16'd256;
	localparam logic [15:0] DERIV_GAIN_RST  = 16'd0;
	localparam logic [14:0] FORCE_LIMIT_RST = 15'd32767;
	localparam logic [14:0] STOP_ZONE_RST   = 15'd29491;

	localparam logic [4:0] MUL1_LAST = 5'd15;
	localparam logic [4:0] MUL2_LAST = 5'd19;
	localparam logic [4:0] DIV_LAST  = 5'd15;
	localparam logic [4:0] TMUL_LAST = 5'd15;
	localparam logic [4:0] TDIV_LAST = 5'd14;

	typedef logic [FieldW-1:0] field_t;

endpackage

### hw/rtl/steer_servo_pd_force.sv
// A result is loaded into the output register after the multiply, sum, divide and
// saturate steps, plus a taper multiply and divide when the stop-zone taper applies;
// the next input beat is taken once that load is done. The time goes to bit-serial
// shift-and-add multipliers and restoring dividers retiring one quotient bit per cycle.
// A finished result waits in an output register, so a new beat is accepted meanwhile.
// Reset restores the register defaults and clears the stored error and its valid flag.
module steer_servo_pd_force
	import ssp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  field_t      target_pos,
	input  field_t      actual_pos,
	input  field_t      step_time_us,

	output logic        out_valid,
	input  logic        out_ready,
	output field_t      force_cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL1  = 4'd1;
	localparam logic [3:0] ST_MUL2  = 4'd2;
	localparam logic [3:0] ST_SUM   = 4'd3;
	localparam logic [3:0] ST_ABS   = 4'd4;
	localparam logic [3:0] ST_CHK   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_SAT   = 4'd7;
	localparam logic [3:0] ST_TPREP = 4'd8;
	localparam logic [3:0] ST_TMUL  = 4'd9;
	localparam logic [3:0] ST_TDIV  = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	logic [3:0]  state_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;
	field_t      force_q;

	logic [15:0] prop_gain_q;
	logic [15:0] deriv_gain_q;
	logic [14:0] force_limit_q;
	logic [14:0] stop_zone_q;

	logic [16:0] last_error_q;
	logic        have_last_q;

	logic        err_neg_q;
	logic [15:0] err_mag_q;
	logic        dif_neg_q;
	logic [15:0] dt_q;
	field_t      act_q;

	logic [15:0] mp_a_q;
	logic [47:0] mc_a_q;
	logic [47:0] acc_a_q;
	logic [19:0] mp_b_q;
	logic [52:0] mc_b_q;
	logic [52:0] acc_b_q;

	logic [57:0] sum_q;
	logic        num_neg_q;
	logic [56:0] rem_q;
	logic [46:0] div_sh_q;
	logic [15:0] quo_q;
	logic        ovf_q;
	logic [14:0] mag_q;
	logic        u_neg_q;

	logic        in_acc;
	logic        out_load;
	logic [16:0] err;
	logic [17:0] dif;
	logic [15:0] dt_floor;
	logic [47:0] acc_a_nx;
	logic [52:0] acc_b_nx;
	logic [57:0] t1;
	logic [57:0] t2;
	logic [57:0] s1;
	logic [57:0] s2;
	logic [57:0] sum_neg;
	logic [56:0] div_ext;
	logic        div_ge;
	logic [56:0] rem_nx;
	logic [15:0] quo_nx;
	logic [15:0] act_abs;
	logic        act_pos;
	logic        taper;
	logic [15:0] taper_w;
	logic [15:0] taper_dz;
	logic [15:0] mag_ext;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign force_cmd = force_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		err      = {target_pos[15], target_pos} - {actual_pos[15], actual_pos};
		dif      = have_last_q ? ({err[16], err} - {last_error_q[16], last_error_q}) : 18'd0;
		dt_floor = (step_time_us < MIN_STEP_US) ? MIN_STEP_US : step_time_us;

		acc_a_nx = acc_a_q + (mp_a_q[0] ? mc_a_q : 48'd0);
		acc_b_nx = acc_b_q + (mp_b_q[0] ? mc_b_q : 53'd0);

		t1      = {2'b00, acc_a_q, 8'h00};
		t2      = {5'd0, acc_b_q};
		s1      = err_neg_q ? (58'd0 - t1) : t1;
		s2      = dif_neg_q ? (58'd0 - t2) : t2;
		sum_neg = 58'd0 - sum_q;

		div_ext = {10'd0, div_sh_q};
		div_ge  = (div_ext <= rem_q);
		rem_nx  = div_ge ? (rem_q - div_ext) : rem_q;
		quo_nx  = {quo_q[14:0], div_ge};

		act_abs  = act_q[15] ? (16'd0 - act_q) : act_q;
		act_pos  = !act_q[15] && (act_q != 16'd0);
		taper    = (mag_q != 15'd0) && (u_neg_q ? act_pos : act_q[15])
			&& (act_abs > {1'b0, stop_zone_q});
		taper_w  = Q15_ONE - act_abs;
		taper_dz = Q15_ONE - {1'b0, stop_zone_q};
		mag_ext  = {1'b0, mag_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= 5'd0;
			out_valid_q   <= 1'b0;
			prop_gain_q   <= PROP_GAIN_RST;
			deriv_gain_q  <= DERIV_GAIN_RST;
			force_limit_q <= FORCE_LIMIT_RST;
			stop_zone_q   <= STOP_ZONE_RST;
			last_error_q  <= 17'd0;
			have_last_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
					REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
					REG_FORCE_LIMIT: force_limit_q <= cfg_data[14:0];
					REG_STOP_ZONE:   stop_zone_q   <= cfg_data[14:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_error_q <= err;
						have_last_q  <= 1'b1;
						cnt_q        <= 5'd0;
						state_q      <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					if (cnt_q == MUL1_LAST) begin
						cnt_q   <= 5'd0;
						state_q <= ST_MUL2;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_MUL2: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == MUL2_LAST) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM:  state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_CHK;
				ST_CHK: begin
					cnt_q   <= 5'd0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT:  state_q <= ST_TPREP;
				ST_TPREP: begin
					cnt_q   <= 5'd0;
					state_q <= taper ? ST_TMUL : ST_DONE;
				end
				ST_TMUL: begin
					if (cnt_q == TMUL_LAST) begin
						cnt_q   <= 5'd0;
						state_q <= ST_TDIV;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_TDIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == TDIV_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			force_q <= u_neg_q ? (16'd0 - mag_ext) : mag_ext;
		end

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					err_neg_q <= err[16];
					err_mag_q <= err[16] ? 16'(17'd0 - err) : err[15:0];
					dif_neg_q <= dif[17];
					dt_q      <= dt_floor;
					act_q     <= actual_pos;
					mp_a_q    <= prop_gain_q;
					mc_a_q    <= {32'd0, dt_floor};
					acc_a_q   <= 48'd0;
					mp_b_q    <= {4'd0, deriv_gain_q};
					mc_b_q    <= {36'd0, (dif[17] ? 17'(18'd0 - dif) : dif[16:0])};
					acc_b_q   <= 53'd0;
				end
			end
			ST_MUL1: begin
				if (cnt_q == MUL1_LAST) begin
					mp_a_q  <= err_mag_q;
					mc_a_q  <= acc_a_nx;
					acc_a_q <= 48'd0;
					mp_b_q  <= US_PER_S;
					mc_b_q  <= acc_b_nx;
					acc_b_q <= 53'd0;
				end else begin
					mp_a_q  <= mp_a_q >> 1;
					mc_a_q  <= mc_a_q << 1;
					acc_a_q <= acc_a_nx;
					mp_b_q  <= mp_b_q >> 1;
					mc_b_q  <= mc_b_q << 1;
					acc_b_q <= acc_b_nx;
				end
			end
			ST_MUL2: begin
				mp_a_q  <= mp_a_q >> 1;
				mc_a_q  <= mc_a_q << 1;
				acc_a_q <= acc_a_nx;
				mp_b_q  <= mp_b_q >> 1;
				mc_b_q  <= mc_b_q << 1;
				acc_b_q <= acc_b_nx;
			end
			ST_SUM: begin
				sum_q <= s1 + s2;
			end
			ST_ABS: begin
				num_neg_q <= sum_q[57];
				rem_q     <= sum_q[57] ? sum_neg[56:0] : sum_q[56:0];
			end
			ST_CHK: begin
				ovf_q    <= (rem_q >= {9'd0, dt_q, 32'd0});
				div_sh_q <= {dt_q, 31'd0};
				quo_q    <= 16'd0;
			end
			ST_DIV: begin
				rem_q    <= rem_nx;
				quo_q    <= quo_nx;
				div_sh_q <= div_sh_q >> 1;
			end
			ST_SAT: begin
				if (ovf_q || (quo_q > {1'b0, force_limit_q})) begin
					mag_q <= force_limit_q;
				end else begin
					mag_q <= quo_q[14:0];
				end
				u_neg_q <= ~num_neg_q;
			end
			ST_TPREP: begin
				mp_a_q   <= taper_w;
				mc_a_q   <= {33'd0, mag_q};
				acc_a_q  <= 48'd0;
				div_sh_q <= {17'd0, taper_dz, 14'd0};
				quo_q    <= 16'd0;
			end
			ST_TMUL: begin
				mp_a_q  <= mp_a_q >> 1;
				mc_a_q  <= mc_a_q << 1;
				acc_a_q <= acc_a_nx;
				if (cnt_q == TMUL_LAST) begin
					rem_q <= {27'd0, acc_a_nx[29:0]};
				end
			end
			ST_TDIV: begin
				rem_q    <= rem_nx;
				quo_q    <= quo_nx;
				div_sh_q <= div_sh_q >> 1;
				if (cnt_q == TDIV_LAST) begin
					mag_q <= quo_nx[14:0];
				end
			end
			default: ;
		endcase
	end

endmodule
